// File: src/aimd_pkg.sv
// shared constants and types for the aimd bitrate controller
package aimd_pkg;

	// default width of the internal rate register
	localparam int RATE_BITS_DEF = 20;

	// field and register widths
	localparam int CFG_W  = 20;
	localparam int STEP_W = 16;
	localparam int RTT_W  = 16;
	localparam int LOSS_W = 17;
	localparam int BW_W   = 20;
	localparam int OUT_W  = 20;

	// apb port geometry
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int REG_COUNT = 6;

	// register map, index = paddr / 4
	typedef enum logic [2:0] {
		REG_START = 3'd0,
		REG_MAX   = 3'd1,
		REG_MIN   = 3'd2,
		REG_STEP  = 3'd3,
		REG_RTT   = 3'd4,
		REG_LOSS  = 3'd5
	} reg_idx_t;

	// register reset values
	localparam logic [CFG_W-1:0]  START_RST = 20'd2000;
	localparam logic [CFG_W-1:0]  MAX_RST   = 20'd1048575;
	localparam logic [CFG_W-1:0]  MIN_RST   = 20'd200;
	localparam logic [STEP_W-1:0] STEP_RST  = 16'd500;
	localparam logic [RTT_W-1:0]  RTT_RST   = 16'd250;
	localparam logic [LOSS_W-1:0] LOSS_RST  = 17'd3276;

	// stable count saturation and the count from which the rate grows
	localparam logic [1:0] STABLE_MAX  = 2'd3;
	localparam logic [1:0] STABLE_GROW = 2'd2;

	// bandwidth cap: floor(9*bw/10), 9*bw fits 24 bits, exact reciprocal of 10
	localparam int BWX9_W     = BW_W + 4;
	localparam int BW_DIV_SH  = BWX9_W + 4;
	localparam int BW_DIV_M_W = BWX9_W + 1;
	localparam logic [BW_DIV_M_W-1:0] BW_DIV_M = BW_DIV_M_W'(((64'd1 << BW_DIV_SH) + 64'd9) / 64'd10);

endpackage

// File: src/aimd_bitrate_controller.sv
// aimd bitrate controller: input register, combinational rate update, result register
//
//  channel | handshake         | payload
//  --------+-------------------+------------------------------------------------
//  in      | in_valid/in_ready | req_type, rtt_ms, loss_q16, bw_kbps
//  out     | out_valid/out_ready | target_bitrate, upgrade_ok, keyframe_now
//  apb     | psel/penable      | pwrite, paddr, pwdata, prdata, pready
//
// one request per cycle sustained while out_ready keeps up; a result is loaded into
// the result register when its request leaves the input register.
// the rate update is one pass of adders, a compare chain and two constant
// reciprocal products for the divisions by ten, all feeding the state directly.
// reset clears the pipeline valids and loads the configuration and state registers with their reset values.
// when out_ready stays low one more request is held in the input register;
// keyframe requests still drain since they leave no result.
module aimd_bitrate_controller #(
	parameter int RATE_BITS = aimd_pkg::RATE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             req_type,
	input  logic [aimd_pkg::RTT_W-1:0]       rtt_ms,
	input  logic [aimd_pkg::LOSS_W-1:0]      loss_q16,
	input  logic [aimd_pkg::BW_W-1:0]        bw_kbps,
	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [aimd_pkg::OUT_W-1:0]       target_bitrate,
	output logic                             upgrade_ok,
	output logic                             keyframe_now,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [aimd_pkg::ADDR_W-1:0]      paddr,
	input  logic [aimd_pkg::DATA_W-1:0]      pwdata,
	output logic [aimd_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);

	// compare width covering both the rate and the 20 bit registers
	localparam int CW = (RATE_BITS > aimd_pkg::CFG_W) ? RATE_BITS : aimd_pkg::CFG_W;
	// 7*rate width and exact reciprocal of ten for it
	localparam int YW = RATE_BITS + 3;
	localparam int DK = YW + 4;
	localparam int MW = YW + 1;
	localparam int PW = YW + MW;
	localparam logic [MW-1:0] DIV10_M = MW'(((64'd1 << DK) + 64'd9) / 64'd10);
	localparam int BPW = aimd_pkg::BWX9_W + aimd_pkg::BW_DIV_M_W;

	// configuration registers
	logic [aimd_pkg::CFG_W-1:0]  start_q;
	logic [aimd_pkg::CFG_W-1:0]  max_q;
	logic [aimd_pkg::CFG_W-1:0]  min_q;
	logic [aimd_pkg::STEP_W-1:0] step_q;
	logic [aimd_pkg::RTT_W-1:0]  rtt_lim_q;
	logic [aimd_pkg::LOSS_W-1:0] loss_lim_q;

	// controller state
	logic [RATE_BITS-1:0] rate_q;
	logic [1:0]           stable_q;
	logic                 pending_q;

	// input register
	logic                        valid_s1;
	logic                        req_s1;
	logic [aimd_pkg::RTT_W-1:0]  rtt_s1;
	logic [aimd_pkg::LOSS_W-1:0] loss_s1;
	logic [aimd_pkg::BW_W-1:0]   bw_s1;

	// result register
	logic                       out_valid_q;
	logic [aimd_pkg::OUT_W-1:0] target_q;
	logic                       upgrade_q;
	logic                       kf_q;

	logic                 cfg_wr;
	aimd_pkg::reg_idx_t   cfg_idx;
	logic                 advance;

	// update datapath
	logic                 congested;
	logic [YW-1:0]        rate_x7;
	logic [PW-1:0]        div_prod;
	logic [RATE_BITS-1:0] dec_q;
	logic [CW-1:0]        dec_rate;
	logic                 drop;
	logic [1:0]           stable_inc;
	logic [CW:0]          sum;
	logic [aimd_pkg::BWX9_W-1:0] bw_x9;
	logic [BPW-1:0]       bw_prod;
	logic [aimd_pkg::BW_W-1:0]   bw_cap;
	logic [CW:0]          capped_bw;
	logic [CW:0]          capped_max;
	logic [RATE_BITS-1:0] rate_nxt;
	logic [1:0]           stable_nxt;
	logic                 pending_nxt;
	logic                 upgrade_nxt;
	logic                 kf_nxt;

	// apb decode
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = aimd_pkg::reg_idx_t'(paddr[aimd_pkg::ADDR_W-1:2]);
	assign pready  = 1'b1;

	// register readback
	always_comb begin
		unique case (cfg_idx)
			aimd_pkg::REG_START: prdata = aimd_pkg::DATA_W'(start_q);
			aimd_pkg::REG_MAX:   prdata = aimd_pkg::DATA_W'(max_q);
			aimd_pkg::REG_MIN:   prdata = aimd_pkg::DATA_W'(min_q);
			aimd_pkg::REG_STEP:  prdata = aimd_pkg::DATA_W'(step_q);
			aimd_pkg::REG_RTT:   prdata = aimd_pkg::DATA_W'(rtt_lim_q);
			aimd_pkg::REG_LOSS:  prdata = aimd_pkg::DATA_W'(loss_lim_q);
			default:             prdata = '0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= aimd_pkg::START_RST;
			max_q      <= aimd_pkg::MAX_RST;
			min_q      <= aimd_pkg::MIN_RST;
			step_q     <= aimd_pkg::STEP_RST;
			rtt_lim_q  <= aimd_pkg::RTT_RST;
			loss_lim_q <= aimd_pkg::LOSS_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				aimd_pkg::REG_START: start_q    <= pwdata[aimd_pkg::CFG_W-1:0];
				aimd_pkg::REG_MAX:   max_q      <= pwdata[aimd_pkg::CFG_W-1:0];
				aimd_pkg::REG_MIN:   min_q      <= pwdata[aimd_pkg::CFG_W-1:0];
				aimd_pkg::REG_STEP:  step_q     <= pwdata[aimd_pkg::STEP_W-1:0];
				aimd_pkg::REG_RTT:   rtt_lim_q  <= pwdata[aimd_pkg::RTT_W-1:0];
				aimd_pkg::REG_LOSS:  loss_lim_q <= pwdata[aimd_pkg::LOSS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// handshake: the held request moves on unless its result slot is blocked
	assign advance  = valid_s1 && (req_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1  <= req_type;
			rtt_s1  <= rtt_ms;
			loss_s1 <= loss_q16;
			bw_s1   <= bw_kbps;
		end
	end

	// congestion test
	assign congested = (loss_s1 > loss_lim_q) || (rtt_s1 > rtt_lim_q);

	// multiplicative decrease: floor(7*rate/10), raised to the minimum
	assign rate_x7  = (YW'(rate_q) << 3) - YW'(rate_q);
	assign div_prod = PW'(rate_x7) * PW'(DIV10_M);
	assign dec_q    = RATE_BITS'(div_prod >> DK);
	assign dec_rate = (CW'(dec_q) < CW'(min_q)) ? CW'(min_q) : CW'(dec_q);
	assign drop     = dec_rate < CW'(rate_q);

	// additive increase, capped at 9/10 of a known bandwidth, then at the maximum
	assign stable_inc = (stable_q == aimd_pkg::STABLE_MAX) ? stable_q : stable_q + 2'd1;
	assign sum        = (CW+1)'(rate_q) + (CW+1)'(step_q);
	assign bw_x9      = (aimd_pkg::BWX9_W'(bw_s1) << 3) + aimd_pkg::BWX9_W'(bw_s1);
	assign bw_prod    = BPW'(bw_x9) * BPW'(aimd_pkg::BW_DIV_M);
	assign bw_cap     = aimd_pkg::BW_W'(bw_prod >> aimd_pkg::BW_DIV_SH);
	assign capped_bw  = ((bw_s1 != '0) && (sum > (CW+1)'(bw_cap))) ? (CW+1)'(bw_cap) : sum;
	assign capped_max = (capped_bw > (CW+1)'(max_q)) ? (CW+1)'(max_q) : capped_bw;

	// next state and result
	always_comb begin
		rate_nxt    = rate_q;
		stable_nxt  = stable_q;
		pending_nxt = pending_q;
		upgrade_nxt = 1'b0;
		kf_nxt      = 1'b0;
		if (req_s1) begin
			pending_nxt = 1'b1;
		end else begin
			if (congested) begin
				rate_nxt   = RATE_BITS'(dec_rate);
				stable_nxt = 2'd0;
				kf_nxt     = drop;
			end else begin
				stable_nxt = stable_inc;
				if (stable_inc >= aimd_pkg::STABLE_GROW) begin
					rate_nxt    = RATE_BITS'(capped_max);
					upgrade_nxt = 1'b1;
				end
			end
			kf_nxt      = kf_nxt || pending_q;
			pending_nxt = 1'b0;
		end
	end

	// controller state, reloaded by a start rate write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= RATE_BITS'(aimd_pkg::START_RST);
			stable_q  <= 2'd0;
			pending_q <= 1'b0;
		end else if (cfg_wr && (cfg_idx == aimd_pkg::REG_START)) begin
			rate_q    <= RATE_BITS'(pwdata[aimd_pkg::CFG_W-1:0]);
			stable_q  <= 2'd0;
			pending_q <= 1'b0;
		end else if (advance) begin
			rate_q    <= rate_nxt;
			stable_q  <= stable_nxt;
			pending_q <= pending_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && !req_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !req_s1) begin
			target_q  <= aimd_pkg::OUT_W'(rate_nxt);
			upgrade_q <= upgrade_nxt;
			kf_q      <= kf_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign target_bitrate = target_q;
	assign upgrade_ok     = upgrade_q;
	assign keyframe_now   = kf_q;

endmodule

// File: src/aimd_chk.sv
// port-level checks for the aimd bitrate controller, bound to the top level
module aimd_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [aimd_pkg::OUT_W-1:0]  target_bitrate,
	input logic                        upgrade_ok,
	input logic                        keyframe_now,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [aimd_pkg::ADDR_W-1:0] paddr,
	input logic [aimd_pkg::DATA_W-1:0] pwdata,
	input logic [aimd_pkg::DATA_W-1:0] prdata
);

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(target_bitrate)
			&& $stable(upgrade_ok) && $stable(keyframe_now))
		else $error("result changed while stalled");

	// with no result waiting the block always takes a request
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused with the result slot empty");

	// requests are only refused behind a result that is itself stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("request refused without a stalled result");

	// a register reads back the low 16 bits of what was written to it
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && (int'(paddr[aimd_pkg::ADDR_W-1:2]) < aimd_pkg::REG_COUNT)
		|=> (psel && (paddr == $past(paddr)))
			|-> (prdata[aimd_pkg::STEP_W-1:0] == $past(pwdata[aimd_pkg::STEP_W-1:0])))
		else $error("register readback mismatch");

endmodule

bind aimd_bitrate_controller aimd_chk u_aimd_chk (.*);

// File: tb/sv/tb_top.sv
// self-checking testbench for the aimd bitrate controller
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit REQ_MEASURE  = 1'b0;
	localparam bit REQ_KEYFRAME = 1'b1;

	// addresses past the register map, writes there must be dropped
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [aimd_pkg::OUT_W-1:0] target;
		logic                       upgrade;
		logic                       keyframe;
	} rate_result_t;

	// mirror of the controller state and registers, predicts each result
	class rate_scoreboard;
		logic [aimd_pkg::CFG_W-1:0]  start_rate;
		logic [aimd_pkg::CFG_W-1:0]  max_rate;
		logic [aimd_pkg::CFG_W-1:0]  min_rate;
		logic [aimd_pkg::STEP_W-1:0] step;
		logic [aimd_pkg::RTT_W-1:0]  rtt_lim;
		logic [aimd_pkg::LOSS_W-1:0] loss_lim;
		logic [aimd_pkg::OUT_W-1:0]  rate;
		logic [1:0]                  stable;
		bit                          kf_pend;
		rate_result_t                expected_rates[$];
		int                          errors;

		function new();
			start_rate = aimd_pkg::START_RST;
			max_rate   = aimd_pkg::MAX_RST;
			min_rate   = aimd_pkg::MIN_RST;
			step       = aimd_pkg::STEP_RST;
			rtt_lim    = aimd_pkg::RTT_RST;
			loss_lim   = aimd_pkg::LOSS_RST;
			rate       = aimd_pkg::START_RST;
			stable     = '0;
			kf_pend    = 1'b0;
			errors     = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [aimd_pkg::DATA_W-1:0] data);
			case (idx)
				aimd_pkg::REG_START: begin
					start_rate = data[aimd_pkg::CFG_W-1:0];
					rate       = data[aimd_pkg::CFG_W-1:0];
					stable     = '0;
					kf_pend    = 1'b0;
				end
				aimd_pkg::REG_MAX:  max_rate = data[aimd_pkg::CFG_W-1:0];
				aimd_pkg::REG_MIN:  min_rate = data[aimd_pkg::CFG_W-1:0];
				aimd_pkg::REG_STEP: step     = data[aimd_pkg::STEP_W-1:0];
				aimd_pkg::REG_RTT:  rtt_lim  = data[aimd_pkg::RTT_W-1:0];
				aimd_pkg::REG_LOSS: loss_lim = data[aimd_pkg::LOSS_W-1:0];
				default: ;
			endcase
		endfunction

		// one accepted request: update the mirrored state, queue the result
		function void note_request(bit kind, logic [aimd_pkg::RTT_W-1:0] rtt,
				logic [aimd_pkg::LOSS_W-1:0] loss, logic [aimd_pkg::BW_W-1:0] bw);
			logic [63:0] cur;
			logic [63:0] nr;
			logic [63:0] cap;
			rate_result_t res;
			if (kind == REQ_KEYFRAME) begin
				kf_pend = 1'b1;
				return;
			end
			cur = 64'(rate);
			res.upgrade  = 1'b0;
			res.keyframe = 1'b0;
			if (loss > loss_lim || rtt > rtt_lim) begin
				// multiplicative decrease, floored at the minimum
				nr = (cur * 64'd7) / 64'd10;
				if (nr < 64'(min_rate))
					nr = 64'(min_rate);
				if (nr < cur)
					res.keyframe = 1'b1;
				rate   = nr[aimd_pkg::OUT_W-1:0];
				stable = '0;
			end else begin
				if (stable < aimd_pkg::STABLE_MAX)
					stable = stable + 2'd1;
				if (stable >= aimd_pkg::STABLE_GROW) begin
					// additive increase, bandwidth cap, then the maximum
					nr  = cur + 64'(step);
					cap = (64'(bw) * 64'd9) / 64'd10;
					if (bw != '0 && nr > cap)
						nr = cap;
					if (nr > 64'(max_rate))
						nr = 64'(max_rate);
					rate        = nr[aimd_pkg::OUT_W-1:0];
					res.upgrade = 1'b1;
				end
			end
			if (kf_pend) begin
				res.keyframe = 1'b1;
				kf_pend      = 1'b0;
			end
			res.target = rate;
			expected_rates.push_back(res);
		endfunction

		function void check_result(logic [aimd_pkg::OUT_W-1:0] target, logic upgrade,
				logic keyframe);
			rate_result_t want;
			if (expected_rates.size() == 0) begin
				$error("unexpected result: target_bitrate %0d", target);
				errors++;
				return;
			end
			want = expected_rates.pop_front();
			if (target !== want.target) begin
				$error("target_bitrate: expected %0d, got %0d", want.target, target);
				errors++;
			end
			if (upgrade !== want.upgrade) begin
				$error("upgrade_ok: expected %0d, got %0d", want.upgrade, upgrade);
				errors++;
			end
			if (keyframe !== want.keyframe) begin
				$error("keyframe_now: expected %0d, got %0d", want.keyframe, keyframe);
				errors++;
			end
		endfunction

		function int pending();
			return expected_rates.size();
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic                        req_type;
	logic [aimd_pkg::RTT_W-1:0]  rtt_ms;
	logic [aimd_pkg::LOSS_W-1:0] loss_q16;
	logic [aimd_pkg::BW_W-1:0]   bw_kbps;
	logic                        out_valid;
	logic                        out_ready;
	logic [aimd_pkg::OUT_W-1:0]  target_bitrate;
	logic                        upgrade_ok;
	logic                        keyframe_now;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [aimd_pkg::ADDR_W-1:0] paddr;
	logic [aimd_pkg::DATA_W-1:0] pwdata;
	logic [aimd_pkg::DATA_W-1:0] prdata;
	logic                        pready;

	rate_scoreboard sb = new();

	bit calm;
	int stall_asked;
	int stall_served;
	int cycle_count;

	aimd_bitrate_controller i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.rtt_ms         (rtt_ms),
		.loss_q16       (loss_q16),
		.bw_kbps        (bw_kbps),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.target_bitrate (target_bitrate),
		.upgrade_ok     (upgrade_ok),
		.keyframe_now   (keyframe_now),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: random back-pressure, long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_served != stall_asked) begin
				out_ready <= 1'b0;
				repeat (STALL_CYCLES - 1) @(negedge clk);
				stall_served++;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 31);
			end
		end
	end

	// compare every accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(target_bitrate, upgrade_ok, keyframe_now);
	end

	// offer one request and hold it until taken
	task automatic send_request(input bit kind, input logic [aimd_pkg::RTT_W-1:0] rtt,
			input logic [aimd_pkg::LOSS_W-1:0] loss, input logic [aimd_pkg::BW_W-1:0] bw);
		while (!calm && $urandom_range(99) < 31) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= kind;
		rtt_ms   <= rtt;
		loss_q16 <= loss;
		bw_kbps  <= bw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(kind, rtt, loss, bw);
	endtask

	// mostly quiet measurements near the limits, some congestion and keyframes
	task automatic send_random_request();
		int                          mode;
		bit                          kind;
		logic [aimd_pkg::RTT_W-1:0]  rtt;
		logic [aimd_pkg::LOSS_W-1:0] loss;
		logic [aimd_pkg::BW_W-1:0]   bw;
		kind = ($urandom_range(99) < 10) ? REQ_KEYFRAME : REQ_MEASURE;
		mode = int'($urandom_range(9));
		rtt  = aimd_pkg::RTT_W'($urandom_range(0, int'(sb.rtt_lim)));
		loss = aimd_pkg::LOSS_W'($urandom_range(0, int'(sb.loss_lim)));
		if (mode == 7 || mode == 9)
			rtt = aimd_pkg::RTT_W'($urandom());
		if (mode == 8 || mode == 9)
			loss = aimd_pkg::LOSS_W'($urandom());
		case ($urandom_range(3))
			0: bw = '0;
			1: bw = aimd_pkg::BW_W'($urandom());
			default: bw = aimd_pkg::BW_W'($urandom_range(0, 2 * int'(sb.rate) + 1000));
		endcase
		send_request(kind, rtt, loss, bw);
	endtask

	// register write in a setup phase and then an access phase
	task automatic write_reg(input logic [2:0] idx,
			input logic [aimd_pkg::DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// stop offering, let every result and any keyframe request drain
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_all(input logic [aimd_pkg::DATA_W-1:0] start_v,
			input logic [aimd_pkg::DATA_W-1:0] max_v,
			input logic [aimd_pkg::DATA_W-1:0] min_v,
			input logic [aimd_pkg::DATA_W-1:0] step_v,
			input logic [aimd_pkg::DATA_W-1:0] rtt_v,
			input logic [aimd_pkg::DATA_W-1:0] loss_v);
		write_reg(aimd_pkg::REG_START, start_v);
		write_reg(aimd_pkg::REG_MAX, max_v);
		write_reg(aimd_pkg::REG_MIN, min_v);
		write_reg(aimd_pkg::REG_STEP, step_v);
		write_reg(aimd_pkg::REG_RTT, rtt_v);
		write_reg(aimd_pkg::REG_LOSS, loss_v);
		write_reg(REG_SPARE_A, $urandom());
		write_reg(REG_SPARE_B, $urandom());
	endtask

	// register settings per random phase, extremes first
	task automatic phase_config(input int ph);
		int s;
		case (ph)
			0: write_all('1, '1, '1, '1, '1, '1);
			1: write_all('0, '0, '0, '0, '0, '0);
			4: write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
			5: write_all($urandom_range(100, 20000), $urandom_range(0, 30000),
				$urandom_range(0, 40000), $urandom_range(0, 8000),
				$urandom_range(20, 800), $urandom_range(0, 30000));
			default: begin
				s = $urandom_range(100, 50000);
				write_all(s, $urandom_range(s, 1048575), $urandom_range(0, 2000),
					$urandom_range(0, 5000), $urandom_range(50, 1000),
					$urandom_range(0, 20000));
			end
		endcase
	endtask

	// stimulus
	initial begin
		int n_items;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		req_type     = REQ_MEASURE;
		rtt_ms       = '0;
		loss_q16     = '0;
		bw_kbps      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		calm         = 1'b0;
		stall_asked  = 0;
		stall_served = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: growth, bandwidth cap, limits exactly met
		send_request(REQ_MEASURE, 16'd0, 17'd0, 20'd0);
		send_request(REQ_MEASURE, 16'd250, 17'd3276, 20'd0);
		send_request(REQ_MEASURE, 16'd0, 17'd0, 20'd2000);
		send_request(REQ_MEASURE, 16'd0, 17'd0, 20'hFFFFF);
		// pending keyframe on a quiet interval
		send_request(REQ_KEYFRAME, 16'hFFFF, 17'h1FFFF, 20'hFFFFF);
		send_request(REQ_MEASURE, 16'd10, 17'd100, 20'd0);
		// congestion by loss, by rtt, by both
		send_request(REQ_MEASURE, 16'd0, 17'd3277, 20'd0);
		send_request(REQ_MEASURE, 16'd251, 17'd0, 20'd0);
		send_request(REQ_KEYFRAME, 16'd0, 17'd0, 20'd0);
		send_request(REQ_KEYFRAME, 16'd0, 17'd0, 20'd0);
		send_request(REQ_MEASURE, 16'hFFFF, 17'd65536, 20'd0);
		// decrease down to the minimum and stay pinned there
		repeat (6) send_request(REQ_MEASURE, 16'd0, 17'h1FFFF, 20'h5A5A5);
		// cap to zero by a tiny bandwidth, then minimum above the old rate
		send_request(REQ_MEASURE, 16'd0, 17'd0, 20'd0);
		send_request(REQ_MEASURE, 16'd0, 17'd0, 20'd1);
		send_request(REQ_MEASURE, 16'd300, 17'd0, 20'd0);
		settle();

		// minimum above the maximum
		write_all(32'd3000, 32'd1000, 32'd5000, 32'd65535, 32'd250, 32'd3276);
		send_request(REQ_MEASURE, 16'd0, 17'd65536, 20'd0);
		send_request(REQ_MEASURE, 16'd0, 17'd0, 20'd0);
		send_request(REQ_MEASURE, 16'd0, 17'd0, 20'd0);
		send_request(REQ_MEASURE, 16'd0, 17'd0, 20'd800000);
		send_request(REQ_MEASURE, 16'd1000, 17'd0, 20'd0);
		settle();

		// random phases
		for (int ph = 0; ph < 6; ph++) begin
			phase_config(ph);
			n_items = (ph == 0) ? 40 : (ph == 1) ? 60 : 100;
			if (ph == 3)
				stall_asked++;
			for (int i = 0; i < n_items; i++) begin
				calm = (ph == 2 && i < 60);
				send_random_request();
			end
			calm = 1'b0;
			settle();
		end

		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
